>>> rtl/tdw_pkg.sv
// Shared types and codes for the task delay / wake table.
// Action and status codes plus the controller to datapath command and status words.
// No dependencies.
package tdw_pkg;

  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_DELAY  = 3'd1;
  localparam logic [2:0] ACT_WAIT   = 3'd2;
  localparam logic [2:0] ACT_FIND   = 3'd3;
  localparam logic [2:0] ACT_CREATE = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NO_TASK = 2'd2;

  localparam int MAX_SLOTS = 16;

  typedef struct packed {
    logic accept;
    logic step;
    logic finish;
  } tdw_cmd_t;

  typedef struct packed {
    logic in_scan;
    logic at_end;
    logic step_emits;
    logic finish_emits;
    logic out_free;
  } tdw_stat_t;

endpackage

>>> rtl/tdw_in_if.sv
// Input channel of the task delay / wake table: valid, ready and one action word.
// No dependencies.
interface tdw_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [3:0]  task_id;
  logic [31:0] ticks;
  logic [7:0]  lock_id;
  logic [7:0]  priority_req;

  modport source(output valid, action, task_id, ticks, lock_id, priority_req, input ready);
  modport sink(input valid, action, task_id, ticks, lock_id, priority_req, output ready);
endinterface

>>> rtl/tdw_out_if.sv
// Result channel of the task delay / wake table: valid, ready and one result word.
// No dependencies.
interface tdw_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] result_task;
  logic       found;
  logic [1:0] status;
  logic       last;

  modport source(output valid, result_task, found, status, last, input ready);
  modport sink(input valid, result_task, found, status, last, output ready);
endinterface

>>> rtl/tdw_ram.sv
// Generic single write port RAM with registered read.
// No dependencies.
module tdw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/tdw_ctrl.sv
// Controller of the task delay / wake table: idle / scan sequencing.
// Depends on tdw_pkg for the command and status words.
module tdw_ctrl import tdw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  tdw_stat_t stat,
  output tdw_cmd_t  cmd
);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        in_ready   = stat.out_free;
        cmd.accept = in_valid && stat.out_free;
        if (cmd.accept && stat.in_scan) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step   = !stat.at_end && (!stat.step_emits || stat.out_free);
        cmd.finish = stat.at_end && (!stat.finish_emits || stat.out_free);
        if (cmd.finish) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/tdw_dpath.sv
// Datapath of the task delay / wake table: tick counter, task table, scan and result register.
// Depends on tdw_pkg and tdw_ram.
module tdw_dpath import tdw_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  tdw_cmd_t    cmd,
  output tdw_stat_t   stat,
  input  logic [2:0]  in_action,
  input  logic [3:0]  in_task_id,
  input  logic [31:0] in_ticks,
  input  logic [7:0]  in_lock_id,
  input  logic [7:0]  in_priority_req,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [3:0]  out_result_task,
  output logic        out_found,
  output logic [1:0]  out_status,
  output logic        out_last
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  logic [31:0]      counter_r;
  logic [CNT_W-1:0] count_r;
  logic [SLOTS-1:0] blocked_r, blocked_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic             is_find_r;
  logic [7:0]       lock_r;
  logic             pend_v_r;
  logic [IDX_W-1:0] pend_idx_r;
  logic             have_r;
  logic [IDX_W-1:0] best_idx_r;
  logic [7:0]       best_prio_r;

  logic             out_valid_r;
  logic [3:0]       out_task_r, out_task_nxt;
  logic             out_found_r, out_found_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_load;

  logic             tid_ok, full, hit, better;
  logic [IDX_W-1:0] cur, tid_idx, new_idx;
  logic             is_delay, is_wait, is_create, is_tick_acc;
  logic             wake_we, lock_we, prio_we;
  logic [IDX_W-1:0] waddr;
  logic [31:0]      wake_wdata, wake_rd;
  logic [7:0]       lock_wdata, lock_rd, prio_rd;

  assign tid_ok    = {1'b0, in_task_id} < 5'(count_r);
  assign full      = count_r == CNT_W'(SLOTS);
  assign cur       = scan_r[IDX_W-1:0];
  assign tid_idx   = in_task_id[IDX_W-1:0];
  assign new_idx   = count_r[IDX_W-1:0];
  assign is_delay  = cmd.accept && in_action == ACT_DELAY;
  assign is_wait   = cmd.accept && in_action == ACT_WAIT;
  assign is_create = cmd.accept && in_action == ACT_CREATE;
  assign is_tick_acc = cmd.accept && in_action == ACT_TICK;

  assign wake_we    = (is_delay && tid_ok) || (is_create && !full);
  assign lock_we    = ((is_delay || is_wait) && tid_ok) || (is_create && !full);
  assign prio_we    = is_create && !full;
  assign waddr      = is_create ? new_idx : tid_idx;
  assign wake_wdata = is_create ? 32'd0 : counter_r + in_ticks;
  assign lock_wdata = is_wait ? in_lock_id : 8'd0;

  assign scan_nxt = cmd.accept ? '0 : (cmd.step ? scan_r + 1'b1 : scan_r);

  tdw_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_wake (
    .clk(clk), .we(wake_we), .waddr(waddr), .wdata(wake_wdata),
    .raddr(scan_nxt[IDX_W-1:0]), .rdata(wake_rd)
  );

  tdw_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_lock (
    .clk(clk), .we(lock_we), .waddr(waddr), .wdata(lock_wdata),
    .raddr(scan_nxt[IDX_W-1:0]), .rdata(lock_rd)
  );

  tdw_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_prio (
    .clk(clk), .we(prio_we), .waddr(waddr), .wdata(in_priority_req),
    .raddr(scan_nxt[IDX_W-1:0]), .rdata(prio_rd)
  );

  // read data always belongs to slot scan_r
  always_comb begin
    if (is_find_r) begin
      hit = blocked_r[cur] && lock_rd == lock_r;
    end else begin
      hit = blocked_r[cur] && lock_rd == 8'd0 && wake_rd <= counter_r;
    end
  end

  assign better = !have_r || prio_rd > best_prio_r;

  assign stat.in_scan      = in_action == ACT_TICK || in_action == ACT_FIND;
  assign stat.at_end       = scan_r == count_r;
  assign stat.step_emits   = !is_find_r && hit && pend_v_r;
  assign stat.finish_emits = is_find_r || pend_v_r;
  assign stat.out_free     = !out_valid_r || out_ready;

  always_comb begin
    blocked_nxt = blocked_r;
    if ((is_delay || is_wait) && tid_ok) begin
      blocked_nxt[tid_idx] = 1'b1;
    end
    if (is_create && !full) begin
      blocked_nxt[new_idx] = 1'b0;
    end
    if (cmd.step && !is_find_r && hit) begin
      blocked_nxt[cur] = 1'b0;
    end
  end

  always_comb begin
    out_load       = 1'b0;
    out_task_nxt   = out_task_r;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    if (is_delay || is_wait) begin
      out_load       = 1'b1;
      out_task_nxt   = tid_ok ? in_task_id : 4'd0;
      out_found_nxt  = tid_ok;
      out_status_nxt = tid_ok ? ST_OK : ST_NO_TASK;
      out_last_nxt   = 1'b1;
    end else if (is_create) begin
      out_load       = 1'b1;
      out_task_nxt   = full ? 4'd0 : 4'(count_r);
      out_found_nxt  = !full;
      out_status_nxt = full ? ST_FULL : ST_OK;
      out_last_nxt   = 1'b1;
    end else if (cmd.step && stat.step_emits) begin
      out_load       = 1'b1;
      out_task_nxt   = 4'(pend_idx_r);
      out_found_nxt  = 1'b1;
      out_status_nxt = ST_OK;
      out_last_nxt   = 1'b0;
    end else if (cmd.finish && stat.finish_emits) begin
      out_load       = 1'b1;
      out_status_nxt = ST_OK;
      out_last_nxt   = 1'b1;
      if (is_find_r) begin
        out_task_nxt  = have_r ? 4'(best_idx_r) : 4'd0;
        out_found_nxt = have_r;
      end else begin
        out_task_nxt  = 4'(pend_idx_r);
        out_found_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r   <= '0;
      count_r     <= '0;
      blocked_r   <= '0;
      scan_r      <= '0;
      pend_v_r    <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      blocked_r <= blocked_nxt;
      scan_r    <= scan_nxt;
      if (is_tick_acc) begin
        counter_r <= counter_r + 32'd1;
      end
      if (is_create && !full) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.accept) begin
        pend_v_r <= 1'b0;
        have_r   <= 1'b0;
      end else if (cmd.step && hit) begin
        if (!is_find_r) begin
          pend_v_r <= 1'b1;
        end else if (better) begin
          have_r <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      is_find_r <= in_action == ACT_FIND;
      lock_r    <= in_lock_id;
    end
    if (cmd.step && hit) begin
      if (!is_find_r) begin
        pend_idx_r <= cur;
      end else if (better) begin
        best_idx_r  <= cur;
        best_prio_r <= prio_rd;
      end
    end
    if (out_load) begin
      out_task_r   <= out_task_nxt;
      out_found_r  <= out_found_nxt;
      out_status_r <= out_status_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_task = out_task_r;
  assign out_found       = out_found_r;
  assign out_status      = out_status_r;
  assign out_last        = out_last_r;

endmodule

>>> rtl/task_delay_wake_table_unit.sv
// Task delay / wake table, top level. Delay, wait and create: result word in the cycle after
// accept, next word accepted once the result register is free. Tick and find: one task slot
// scanned per cycle while the output does not stall, the rate set by the single read port of
// the task RAMs; a tick gives one word per woken task, none if none wakes, find one last word.
// Reset clears the tick counter, task count and blocked marks at once; no clearing pass.
// Depends on tdw_pkg, tdw_in_if, tdw_out_if, tdw_ctrl and tdw_dpath.
module task_delay_wake_table_unit import tdw_pkg::*; #(
  parameter int TASK_SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  tdw_in_if.sink    in_ch,
  tdw_out_if.source out_ch
);

  localparam int SLOTS = (TASK_SLOTS < MAX_SLOTS) ? TASK_SLOTS : MAX_SLOTS;

  tdw_cmd_t  cmd;
  tdw_stat_t stat;

  tdw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tdw_dpath #(.SLOTS(SLOTS)) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_action       (in_ch.action),
    .in_task_id      (in_ch.task_id),
    .in_ticks        (in_ch.ticks),
    .in_lock_id      (in_ch.lock_id),
    .in_priority_req (in_ch.priority_req),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_result_task (out_ch.result_task),
    .out_found       (out_ch.found),
    .out_status      (out_ch.status),
    .out_last        (out_ch.last)
  );

`ifndef SYNTHESIS
  a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready &&
     (in_ch.action == ACT_DELAY || in_ch.action == ACT_WAIT || in_ch.action == ACT_CREATE))
    |=> (out_ch.valid && out_ch.last))
    else $error("single-result action did not load a last word");

  a_scan_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && stat.in_scan) |=> !in_ch.ready)
    else $error("input taken while a scan is running");

  a_step_finish_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.step && cmd.finish) && !(cmd.accept && (cmd.step || cmd.finish)))
    else $error("conflicting controller commands");
`endif

endmodule
